@@ design/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Shared widths, codes and defaults of the sorted timestamp table.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned CHANNELS_DEF = 5;

  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;

  localparam logic [STAMP_W-1:0] SIGN_BIAS = {1'b1, {(STAMP_W-1){1'b0}}};

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LAST,
    S_FIRST,
    S_SCAN,
    S_FOUND,
    S_SHIFT,
    S_PUT,
    S_VAL,
    S_RESULT
  } state_e;

endpackage

`default_nettype wire

@@ design/stt_req_if.sv @@
// ----------------------------------------------------------------------------
// stt_req_if
// Request channel of the sorted timestamp table: insert or lookup words.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_req_if;
  import stt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [CHAN_W-1:0]         channel;
  logic signed [STAMP_W-1:0] time_stamp;
  logic [VALUE_W-1:0]        value_in;

  modport source (output valid, req_type, channel, time_stamp, value_in, input ready);
  modport sink   (input valid, req_type, channel, time_stamp, value_in, output ready);
endinterface

`default_nettype wire

@@ design/stt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// stt_rsp_if
// Response channel of the sorted timestamp table: status, value and index.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_rsp_if;
  import stt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] result_status;
  logic [VALUE_W-1:0]  value_out;
  logic [POS_W-1:0]    position;

  modport source (output valid, result_status, value_out, position, input ready);
  modport sink   (input valid, result_status, value_out, position, output ready);
endinterface

`default_nettype wire

@@ design/sorted_timestamp_table.sv @@
// ----------------------------------------------------------------------------
// sorted_timestamp_table
// Per-channel sorted (timestamp, value) record table with floor search.
// ----------------------------------------------------------------------------
// Each request word on req_i either inserts a record into one channel or
// looks up the value at the floor position of a time. Every request gives
// exactly one response word on rsp_o with a status, a value and an index.
// Records live in two single-port-read, single-port-write memories with a
// registered read; all channels share them, CAPACITY entries per channel.
// One request is worked on at a time. The floor search reads one entry
// per cycle, and on insert the shift of later records moves one entry per
// cycle through the same read port, from the last record down to the
// insert slot. A channel number out of range, or a full channel on
// insert, goes from the start state straight to the result state.
// The response sits in an output register, so the next request is taken
// while an earlier response still waits for rsp_o.ready; a stalled
// receiver only holds the block once a second response is ready.
// Reset clears the record counts and the control state; the memories are
// not cleared, since only entries below a channel's count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timestamp_table #(
  parameter int unsigned CAPACITY = stt_pkg::CAPACITY_DEF,
  parameter int unsigned CHANNELS = stt_pkg::CHANNELS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  stt_req_if.sink    req_i,
  stt_rsp_if.source  rsp_o
);
  import stt_pkg::*;

  localparam int unsigned IW       = $clog2(CAPACITY);
  localparam int unsigned NW       = $clog2(CAPACITY + 1);
  localparam int unsigned CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MemDepth = CHANNELS * CAPACITY;
  localparam int unsigned AW       = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  state_e               state_q, state_d;
  req_e                 req_q, req_d;
  logic [CW-1:0]        ch_q, ch_d;
  logic                 ch_ok_q, ch_ok_d;
  logic [AW-1:0]        base_q, base_d;
  logic [STAMP_W-1:0]   key_q, key_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [NW-1:0]        n_q, n_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [IW-1:0]        f_q, f_d;
  logic                 has_q, has_d;
  logic [IW-1:0]        p_q, p_d;
  status_e              res_status_q, res_status_d;
  logic [VALUE_W-1:0]   res_value_q, res_value_d;
  logic [POS_W-1:0]     res_pos_q, res_pos_d;
  logic                 out_vld_q, out_vld_d;
  status_e              out_status_q, out_status_d;
  logic [VALUE_W-1:0]   out_value_q, out_value_d;
  logic [POS_W-1:0]     out_pos_q, out_pos_d;
  logic [NW-1:0]        count_q [CHANNELS];
  logic [NW-1:0]        count_d [CHANNELS];

  logic [STAMP_W-1:0]   stamp_mem [MemDepth];
  logic [VALUE_W-1:0]   value_mem [MemDepth];
  logic                 rd_en;
  logic [IW-1:0]        rd_idx;
  logic [AW-1:0]        rd_addr;
  logic [STAMP_W-1:0]   rd_stamp_q;
  logic [VALUE_W-1:0]   rd_value_q;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic [AW-1:0]        wr_addr;
  logic [STAMP_W-1:0]   wr_stamp;
  logic [VALUE_W-1:0]   wr_value;

  logic                 req_fire;
  logic                 out_free;
  logic [CW-1:0]        ch_in;
  logic [NW-1:0]        n_cur;
  logic                 cap_full;
  logic                 key_ge;
  logic                 key_le;
  logic                 key_eq;
  logic                 scan_end;
  logic [IW-1:0]        p_calc;
  logic                 need_shift;
  logic                 shift_last;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;
  assign ch_in       = CW'(req_i.channel);

  assign n_cur      = count_q[ch_q];
  assign cap_full   = (n_cur >= NW'(CAPACITY));
  assign key_ge     = (key_q >= rd_stamp_q);
  assign key_le     = (key_q <= rd_stamp_q);
  assign key_eq     = (key_q == rd_stamp_q);
  assign scan_end   = ((NW'(idx_q) + NW'(1)) == n_q);
  assign p_calc     = has_q ? (f_q + IW'(1)) : '0;
  assign need_shift = (NW'(p_calc) < n_q);
  assign shift_last = ((idx_q - IW'(1)) == p_q);

  assign rd_addr = base_q + AW'(rd_idx);
  assign wr_addr = base_q + AW'(wr_idx);

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.result_status = out_status_q;
  assign rsp_o.value_out     = out_value_q;
  assign rsp_o.position      = out_pos_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (!ch_ok_q || (req_q == REQ_INSERT && cap_full)) begin
          state_d = S_RESULT;
        end else if (n_cur == '0) begin
          state_d = S_FOUND;
        end else begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = key_ge ? S_FOUND : S_FIRST;
      end
      S_FIRST: begin
        state_d = key_ge ? S_SCAN : S_FOUND;
      end
      S_SCAN: begin
        if (key_le || scan_end) begin
          state_d = S_FOUND;
        end
      end
      S_FOUND: begin
        if (req_q == REQ_LOOKUP) begin
          state_d = has_q ? S_VAL : S_RESULT;
        end else begin
          state_d = need_shift ? S_SHIFT : S_PUT;
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_d = S_PUT;
        end
      end
      S_PUT:    state_d = S_RESULT;
      S_VAL:    state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_d        = req_q;
    ch_d         = ch_q;
    ch_ok_d      = ch_ok_q;
    base_d       = base_q;
    key_d        = key_q;
    val_d        = val_q;
    n_d          = n_q;
    idx_d        = idx_q;
    f_d          = f_q;
    has_d        = has_q;
    p_d          = p_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_pos_d    = res_pos_q;
    count_d      = count_q;
    rd_en        = 1'b0;
    rd_idx       = idx_q;
    wr_en        = 1'b0;
    wr_idx       = idx_q;
    wr_stamp     = rd_stamp_q;
    wr_value     = rd_value_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_pos_d    = out_pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          req_d   = req_e'(req_i.req_type);
          ch_d    = ch_in;
          ch_ok_d = (5'(req_i.channel) < 5'(CHANNELS));
          base_d  = AW'(ch_in) * AW'(CAPACITY);
          key_d   = req_i.time_stamp ^ SIGN_BIAS;
          val_d   = req_i.value_in;
        end
      end
      S_START: begin
        res_value_d = '0;
        res_pos_d   = '0;
        has_d       = 1'b0;
        if (!ch_ok_q) begin
          res_status_d = (req_q == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else if (req_q == REQ_INSERT && cap_full) begin
          res_status_d = ST_FULL;
        end else begin
          n_d    = n_cur;
          rd_en  = 1'b1;
          rd_idx = IW'(n_cur - NW'(1));
        end
      end
      S_LAST: begin
        if (key_ge) begin
          has_d = 1'b1;
          f_d   = IW'(n_q - NW'(1));
        end else begin
          rd_en  = 1'b1;
          rd_idx = '0;
        end
      end
      S_FIRST: begin
        if (key_ge) begin
          idx_d  = IW'(1);
          rd_en  = 1'b1;
          rd_idx = IW'(1);
        end
      end
      S_SCAN: begin
        if (key_le) begin
          has_d = 1'b1;
          f_d   = key_eq ? idx_q : (idx_q - IW'(1));
        end else if (scan_end) begin
          has_d = 1'b1;
          f_d   = IW'(n_q - NW'(2));
        end else begin
          idx_d  = idx_q + IW'(1);
          rd_en  = 1'b1;
          rd_idx = idx_q + IW'(1);
        end
      end
      S_FOUND: begin
        if (req_q == REQ_LOOKUP) begin
          if (has_q) begin
            rd_en  = 1'b1;
            rd_idx = f_q;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end else begin
          p_d   = p_calc;
          idx_d = IW'(n_q);
          if (need_shift) begin
            rd_en  = 1'b1;
            rd_idx = IW'(n_q - NW'(1));
          end
        end
      end
      S_SHIFT: begin
        wr_en  = 1'b1;
        wr_idx = idx_q;
        idx_d  = idx_q - IW'(1);
        if (!shift_last) begin
          rd_en  = 1'b1;
          rd_idx = idx_q - IW'(2);
        end
      end
      S_PUT: begin
        wr_en          = 1'b1;
        wr_idx         = p_q;
        wr_stamp       = key_q;
        wr_value       = val_q;
        count_d[ch_q]  = n_q + NW'(1);
        res_status_d   = ST_OK;
        res_value_d    = '0;
        res_pos_d      = POS_W'(p_q);
      end
      S_VAL: begin
        res_status_d = ST_OK;
        res_value_d  = rd_value_q;
        res_pos_d    = POS_W'(f_q);
      end
      S_RESULT: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_pos_d    = res_pos_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      for (int i = 0; i < int'(CHANNELS); i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    ch_q         <= ch_d;
    ch_ok_q      <= ch_ok_d;
    base_q       <= base_d;
    key_q        <= key_d;
    val_q        <= val_d;
    n_q          <= n_d;
    idx_q        <= idx_d;
    f_q          <= f_d;
    has_q        <= has_d;
    p_q          <= p_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_pos_q    <= out_pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
      value_mem[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      rd_stamp_q <= stamp_mem[rd_addr];
      rd_value_q <= value_mem[rd_addr];
    end
  end

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_START)
    else $error("accepted request did not start the search");

  a_shift_above_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> (idx_q > p_q && req_q == REQ_INSERT))
    else $error("record shift below the insert slot");

  a_count_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |=> count_q[ch_q] == NW'($past(n_q) + NW'(1)))
    else $error("record count not advanced by an insert");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && !out_free) |=> state_q == S_RESULT)
    else $error("pending response dropped while output register busy");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted timestamp table.
// ----------------------------------------------------------------------------
// Request words are sent in bursts with random gaps, and the response side
// stalls on patterns that change over the run. Each accepted request is
// applied to a behavioral copy of the record table, which gives the status,
// value and index the block must return. Responses are checked in order.
// Directed cases cover empty and out-of-range channels, extreme times and
// values, equal timestamps and floors before, at and after the records.
// A full channel is then built up, and a long random mix of inserts and
// lookups follows.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int unsigned CHANNELS       = CHANNELS_DEF;
  localparam int unsigned CAPACITY       = CAPACITY_DEF;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          RANDOM_WORDS   = 1800;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } table_rsp_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_PATTERN,
    STALL_LONG
  } stall_mode_e;

  logic clk_i;
  logic rst_ni;

  stt_req_if req_if ();
  stt_rsp_if rsp_if ();

  sorted_timestamp_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic signed [STAMP_W-1:0] stamp_tbl [CHANNELS][CAPACITY];
  logic [VALUE_W-1:0]        value_tbl [CHANNELS][CAPACITY];
  int                        rec_count [CHANNELS];

  table_rsp_t  pending_answers [$];
  int          mismatches  = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  logic [15:0] stall_pat   = 16'hFFFF;
  int          phase_left  = 0;
  logic [7:0]  rx_tick     = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit floor_index(int ch, logic signed [STAMP_W-1:0] ts,
                                     output int idx);
    int n;
    int i;
    n   = rec_count[ch];
    idx = 0;
    if (n == 0) return 1'b0;
    if (ts >= stamp_tbl[ch][n-1]) begin
      idx = n - 1;
      return 1'b1;
    end
    if (ts < stamp_tbl[ch][0]) return 1'b0;
    i = 1;
    while (i < n && stamp_tbl[ch][i] < ts) i++;
    if (i >= n) i = n - 1;
    idx = (stamp_tbl[ch][i] == ts) ? i : i - 1;
    return 1'b1;
  endfunction

  function automatic table_rsp_t table_apply(req_e kind, logic [CHAN_W-1:0] ch,
                                             logic signed [STAMP_W-1:0] ts,
                                             logic [VALUE_W-1:0] val);
    table_rsp_t ans;
    int         n;
    int         fl;
    int         p;
    bit         hit;
    ans.status = ST_OK;
    ans.value  = '0;
    ans.pos    = '0;
    if (ch >= CHANNELS) begin
      ans.status = (kind == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      n   = rec_count[ch];
      hit = floor_index(ch, ts, fl);
      if (kind == REQ_INSERT) begin
        if (n >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          p = hit ? fl + 1 : 0;
          for (int k = n; k > p; k--) begin
            stamp_tbl[ch][k] = stamp_tbl[ch][k-1];
            value_tbl[ch][k] = value_tbl[ch][k-1];
          end
          stamp_tbl[ch][p] = ts;
          value_tbl[ch][p] = val;
          rec_count[ch]    = n + 1;
          ans.pos          = POS_W'(p);
        end
      end else if (hit) begin
        ans.value = value_tbl[ch][fl];
        ans.pos   = POS_W'(fl);
      end else begin
        ans.status = ST_NOT_FOUND;
      end
    end
    return ans;
  endfunction

  task automatic send_word(req_e kind, logic [CHAN_W-1:0] ch,
                           logic signed [STAMP_W-1:0] ts, logic [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.channel    <= ch;
    req_if.time_stamp <= ts;
    req_if.value_in   <= val;
    do @(posedge clk_i); while (!req_if.ready);
    pending_answers.push_back(table_apply(kind, ch, ts, val));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: response word with none expected: status %0d value %h pos %0d",
                 $realtime, rsp_if.result_status, rsp_if.value_out, rsp_if.position);
        mismatches++;
      end else begin
        table_rsp_t exp_rsp;
        exp_rsp = pending_answers.pop_front();
        if (rsp_if.result_status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   exp_rsp.status, rsp_if.result_status);
          mismatches++;
        end
        if (rsp_if.value_out !== exp_rsp.value) begin
          $display("%0t: value expected %h actual %h", $realtime,
                   exp_rsp.value, rsp_if.value_out);
          mismatches++;
        end
        if (rsp_if.position !== exp_rsp.pos) begin
          $display("%0t: position expected %0d actual %0d", $realtime,
                   exp_rsp.pos, rsp_if.position);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (phase_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 2));
        stall_pat  <= 16'($urandom) | 16'h0001;
        phase_left <= $urandom_range(40, 300);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          rsp_if.ready <= 1'b1;
        end
        STALL_PATTERN: begin
          rsp_if.ready <= stall_pat[rx_tick[3:0]];
        end
        default: begin
          rsp_if.ready <= (rx_tick[5:0] >= 6'd40);
        end
      endcase
      rx_tick <= rx_tick + 8'd1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic test_directed();
    send_word(REQ_LOOKUP, 3'd0, 32'sd0, 32'h1234_5678);
    send_word(REQ_INSERT, 3'd0, 32'sd0, 32'hA5A5_0001);
    send_word(REQ_INSERT, 3'd0, 32'sh8000_0000, 32'h0000_0000);
    send_word(REQ_INSERT, 3'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_INSERT, 3'd0, 32'sd0, 32'hA5A5_0002);
    send_word(REQ_INSERT, 3'd0, 32'sd0, 32'hA5A5_0003);
    send_word(REQ_LOOKUP, 3'd0, 32'sh8000_0000, 32'h0);
    send_word(REQ_LOOKUP, 3'd0, 32'sh8000_0001, 32'h0);
    send_word(REQ_LOOKUP, 3'd0, 32'sd0, 32'h0);
    send_word(REQ_LOOKUP, 3'd0, -32'sd1, 32'h0);
    send_word(REQ_LOOKUP, 3'd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 3'd0, 32'sh7FFF_FFFE, 32'h0);
    send_word(REQ_INSERT, 3'd1, 32'sd100, 32'h5A5A_5A5A);
    send_word(REQ_LOOKUP, 3'd1, 32'sd99, 32'h0);
    send_word(REQ_LOOKUP, 3'd1, 32'sd100, 32'h0);
    send_word(REQ_LOOKUP, 3'd1, 32'sd101, 32'h0);
    send_word(REQ_INSERT, 3'd2, 32'sd5, 32'h0000_0005);
    send_word(REQ_INSERT, 3'd2, -32'sd5, 32'hFFFF_FFFB);
    send_word(REQ_LOOKUP, 3'd2, 32'sd4, 32'h0);
    send_word(REQ_INSERT, 3'd5, 32'sd7, 32'hDEAD_BEEF);
    send_word(REQ_LOOKUP, 3'd6, 32'sd7, 32'h0);
    send_word(REQ_INSERT, 3'd7, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 3'd7, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 3'd0, 32'sd0, 32'h0);
  endtask

  task automatic test_full_channel();
    logic signed [STAMP_W-1:0] ts;
    for (int i = 0; i < CAPACITY + 3; i++) begin
      ts = int'($urandom_range(0, 15));
      send_word(REQ_INSERT, 3'd3, ts, $urandom);
    end
    for (int i = 0; i < 8; i++) begin
      ts = int'($urandom_range(0, 19)) - 2;
      send_word(REQ_LOOKUP, 3'd3, ts, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    req_e                      kind;
    logic [CHAN_W-1:0]         ch;
    logic signed [STAMP_W-1:0] ts;
    int                        pick;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      kind = ($urandom_range(0, 99) < 45) ? REQ_INSERT : REQ_LOOKUP;
      ch   = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom_range(CHANNELS, 7))
                                         : CHAN_W'($urandom_range(0, CHANNELS - 1));
      pick = $urandom_range(0, 7);
      if (pick < 4) begin
        ts = int'($urandom_range(0, 40)) - 20;
      end else if (pick == 4) begin
        ts = 32'h8000_0000 + $urandom_range(0, 8);
      end else if (pick == 5) begin
        ts = 32'h7FFF_FFFF - $urandom_range(0, 8);
      end else begin
        ts = $urandom;
      end
      send_word(kind, ch, ts, $urandom);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_INSERT;
    req_if.channel    = '0;
    req_if.time_stamp = '0;
    req_if.value_in   = '0;
    rsp_if.ready      = 1'b0;
    for (int c = 0; c < CHANNELS; c++) rec_count[c] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_channel();
    test_random_traffic();
    req_if.valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
